FILE: rtl/aes_pkg.sv
// AES-128 package: S-box tables, GF(2^8) helpers and shared types.
package aes_pkg;

   localparam int unsigned KEY_W   = 64;
   localparam int unsigned BLOCK_W = 128;
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [63:0] KEY_HIGH_RESET = 64'h2b28ab097eaef7cf;
   localparam logic [63:0] KEY_LOW_RESET  = 64'h15d2154f16a6883c;
   localparam logic        ACT_ENCRYPT    = 1'b0;
   localparam logic        ACT_DECRYPT    = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 1'b1;

   typedef logic [127:0] block_type;

   // Control from the sequencer to the round unit.
   typedef struct packed {
      logic load;     // take the new block and add the first round key
      logic decrypt;
      logic last;     // final round: no MixColumns
      logic step;     // run one round
   } round_ctl_type;

   localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xt(input logic [7:0] v);
      xt = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // byte k of a block: k = row*4 + col, byte 0 in the top bits
   function automatic logic [7:0] get_byte(input block_type b, input int k);
      get_byte = b[127 - 8*k -: 8];
   endfunction

endpackage

FILE: rtl/aes_key_sched.sv
// AES-128 key schedule: steps the round key forward or backward one round per cycle while a step input is set.
module aes_key_sched import aes_pkg::*; (
   input  logic      clock,
   input  logic      load,      // load the cipher key (round key 0)
   input  logic      fwd_step,  // advance to next round key
   input  logic      bwd_step,  // go back to previous round key
   input  block_type key,
   output block_type round_key
);

   block_type  rk_ff, rk_in;
   logic [7:0] rc_ff, rc_in;

   always_comb begin
      logic [7:0] t [4];
      logic [7:0] rcp;
      for (int r = 0; r < 4; r++) t[r] = 8'h00;
      rk_in = rk_ff;
      rc_in = rc_ff;
      // previous round constant: xt inverse
      rcp = rc_ff[0] ? ({1'b1, rc_ff[7:1]} ^ 8'h0d) : {1'b0, rc_ff[7:1]};
      if (load) begin
         rk_in = key;
         rc_in = 8'h01;
      end else if (fwd_step) begin
         for (int r = 0; r < 4; r++) t[r] = SBOX[get_byte(rk_ff, ((r + 1) % 4) * 4 + 3)];
         t[0] = t[0] ^ rc_ff;
         for (int r = 0; r < 4; r++) begin
            rk_in[127 - 8*(r*4) -: 8] = get_byte(rk_ff, r*4) ^ t[r];
            for (int c = 1; c < 4; c++)
               rk_in[127 - 8*(r*4+c) -: 8] = get_byte(rk_ff, r*4+c) ^ get_byte(rk_in, r*4+c-1);
         end
         rc_in = xt(rc_ff);
      end else if (bwd_step) begin
         // undo: columns 1..3 from xor of neighbors, then column 0 via old column 3
         for (int r = 0; r < 4; r++)
            for (int c = 3; c > 0; c--)
               rk_in[127 - 8*(r*4+c) -: 8] = get_byte(rk_ff, r*4+c) ^ get_byte(rk_ff, r*4+c-1);
         for (int r = 0; r < 4; r++) t[r] = SBOX[get_byte(rk_in, ((r + 1) % 4) * 4 + 3)];
         t[0] = t[0] ^ rcp;
         for (int r = 0; r < 4; r++)
            rk_in[127 - 8*(r*4) -: 8] = get_byte(rk_ff, r*4) ^ t[r];
         rc_in = rcp;
      end
   end

   always_ff @(posedge clock) begin
      rk_ff <= rk_in;
      rc_ff <= rc_in;
   end

   assign round_key = rk_ff;

endmodule

FILE: rtl/aes_round.sv
// AES round unit: one encrypt or decrypt round per cycle on a held state, while ctl.step is set.
module aes_round import aes_pkg::*; (
   input  logic          clock,
   input  round_ctl_type ctl,
   input  block_type     block_in,
   input  block_type     round_key,
   output block_type     state
);

   block_type state_ff, state_in;

   function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
      logic [7:0] r, x;
      r = 8'h00;
      x = a;
      for (int i = 0; i < 4; i++) begin
         if (m[i]) r = r ^ x;
         x = xt(x);
      end
      gm = r;
   endfunction

   always_comb begin
      block_type sr, sb, mc;
      logic [3:0] mat [4];
      logic [7:0] v;
      if (ctl.decrypt) begin
         mat[0] = 4'he; mat[1] = 4'hb; mat[2] = 4'hd; mat[3] = 4'h9;
      end else begin
         mat[0] = 4'h2; mat[1] = 4'h3; mat[2] = 4'h1; mat[3] = 4'h1;
      end
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            sr[127 - 8*(r*4+c) -: 8] = ctl.decrypt ? get_byte(state_ff, r*4 + ((c + 3*r) % 4))
                                                   : get_byte(state_ff, r*4 + ((c + r) % 4));
      for (int k = 0; k < 16; k++)
         sb[127 - 8*k -: 8] = ctl.decrypt ? ISBOX[get_byte(sr, k)] : SBOX[get_byte(sr, k)];
      // decrypt adds the key before InvMixColumns
      if (ctl.decrypt) sb = sb ^ round_key;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int j = 0; j < 4; j++) v = v ^ gm(get_byte(sb, j*4+c), mat[(j - r + 4) % 4]);
            mc[127 - 8*(r*4+c) -: 8] = v;
         end
      if (ctl.last) mc = sb;
      if (!ctl.decrypt) mc = mc ^ round_key;
      state_in = state_ff;
      if (ctl.load) state_in = block_in ^ round_key;
      else if (ctl.step) state_in = mc;
   end

   always_ff @(posedge clock) state_ff <= state_in;

   assign state = state_ff;

endmodule

FILE: rtl/aes128_block_cipher.sv
// AES-128 encrypt/decrypt core: top level with sequencer, key registers and ports.
// One request is handled at a time. An encrypt loads the cipher key, adds round key 0
// and then runs one round per cycle in the shared round unit. A decrypt first walks the
// key schedule forward to round key 10 and then steps it back during the rounds. The
// next request is accepted once the result has been taken. Key writes on the csr port
// take effect for the next request; both key registers reset to the built-in key.
module aes128_block_cipher import aes_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [127:0]         req_tdata,   // block_high, block_low
   input  logic                 req_tuser,   // action
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [127:0]         rsp_tdata,   // result_high, result_low
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_KEY  = 3'd1;
   localparam logic [2:0] ST_FWD  = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_RUN  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]       st_ff, st_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             dec_ff, dec_in;
   block_type        blk_ff, blk_in;
   logic [KEY_W-1:0] key_hi_ff, key_lo_ff;
   block_type        round_key, state;
   round_ctl_type    ctl;
   logic             ks_load, ks_fwd, ks_bwd;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= KEY_HIGH_RESET;
         key_lo_ff <= KEY_LOW_RESET;
      end else if (csr_we && csr_index == CSR_KEY_HIGH) begin
         key_hi_ff <= csr_wdata;
      end else if (csr_we && csr_index == CSR_KEY_LOW) begin
         key_lo_ff <= csr_wdata;
      end
   end

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = (st_ff == ST_OUT);
   assign rsp_tdata  = {state[63:0], state[127:64]};

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      dec_in  = dec_ff;
      blk_in  = blk_ff;
      ks_load = 1'b0;
      ks_fwd  = 1'b0;
      ks_bwd  = 1'b0;
      ctl     = '{load: 1'b0, decrypt: dec_ff, last: (cnt_ff == 4'd10), step: 1'b0};
      case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               blk_in = {req_tdata[63:0], req_tdata[127:64]};
               dec_in = (req_tuser == ACT_DECRYPT);
               st_in  = ST_KEY;
            end
         end
         ST_KEY: begin
            ks_load = 1'b1;
            cnt_in  = 4'd0;
            st_in   = dec_ff ? ST_FWD : ST_LOAD;
         end
         ST_FWD: begin
            ks_fwd = 1'b1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd9) st_in = ST_LOAD;
         end
         ST_LOAD: begin
            ctl.load = 1'b1;
            cnt_in   = 4'd1;
            if (dec_ff) ks_bwd = 1'b1;
            else        ks_fwd = 1'b1;
            st_in    = ST_RUN;
         end
         ST_RUN: begin
            ctl.step = 1'b1;
            cnt_in   = cnt_ff + 4'd1;
            if (dec_ff) ks_bwd = 1'b1;
            else        ks_fwd = 1'b1;
            if (cnt_ff == 4'd10) st_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      cnt_ff <= cnt_in;
      dec_ff <= dec_in;
      blk_ff <= blk_in;
   end

   aes_key_sched u_key (
      .clock     (clock),
      .load      (ks_load),
      .fwd_step  (ks_fwd && !ks_load),
      .bwd_step  (ks_bwd),
      .key       ({key_hi_ff, key_lo_ff}),
      .round_key (round_key)
   );

   aes_round u_round (
      .clock     (clock),
      .ctl       (ctl),
      .block_in  (blk_ff),
      .round_key (round_key),
      .state     (state)
   );

endmodule

FILE: dv/aes128_block_cipher_checker.sv
// Checker for the AES-128 core: tracks the key registers, predicts each block and compares.
module aes128_block_cipher_checker import aes_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [127:0]         req_tdata,
   input  logic                 req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [127:0]         rsp_tdata,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_wdata,
   output int                   fail_count,
   output int                   pending
);

   logic [63:0]  key_hi_q;
   logic [63:0]  key_lo_q;
   logic [127:0] cipher_out_q[$];

   function automatic logic [7:0] dbl(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] m);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 4; i++) begin
         if (m[i]) r ^= a;
         a = dbl(a);
      end
      return r;
   endfunction

   // full AES-128 on one block; row-major bytes, byte 0 in the top bits
   function automatic logic [127:0] aes_block(input logic [127:0] key, input logic [127:0] blk,
                                              input logic act);
      logic [7:0] rk[11][16];
      logic [7:0] s[16];
      logic [7:0] t[16];
      logic [7:0] col[4];
      logic [7:0] rc;
      logic [3:0] coef[4];
      logic [127:0] res;
      int dir;
      for (int k = 0; k < 16; k++) begin
         rk[0][k] = key[127 - 8*k -: 8];
         s[k] = blk[127 - 8*k -: 8];
      end
      rc = 8'h01;
      for (int n = 1; n <= 10; n++) begin
         for (int r = 0; r < 4; r++) col[r] = SBOX[rk[n-1][((r + 1) % 4) * 4 + 3]];
         col[0] ^= rc;
         rc = dbl(rc);
         for (int r = 0; r < 4; r++) begin
            rk[n][r*4] = rk[n-1][r*4] ^ col[r];
            for (int c = 1; c < 4; c++) rk[n][r*4+c] = rk[n-1][r*4+c] ^ rk[n][r*4+c-1];
         end
      end
      if (act == ACT_ENCRYPT) begin
         dir = 1;
         coef = '{4'h2, 4'h3, 4'h1, 4'h1};
      end else begin
         dir = 3;
         coef = '{4'he, 4'hb, 4'hd, 4'h9};
      end
      for (int k = 0; k < 16; k++) s[k] ^= rk[act == ACT_ENCRYPT ? 0 : 10][k];
      for (int i = 1; i <= 10; i++) begin
         // encrypt: shift, sub, mix, key. decrypt: shift, inv sub, key, inv mix.
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) t[r*4+c] = s[r*4 + ((c + r*dir) % 4)];
         for (int k = 0; k < 16; k++)
            s[k] = (act == ACT_ENCRYPT) ? SBOX[t[k]] : ISBOX[t[k]];
         if (act == ACT_DECRYPT)
            for (int k = 0; k < 16; k++) s[k] ^= rk[10 - i][k];
         if (i != 10) begin
            for (int c = 0; c < 4; c++) begin
               for (int r = 0; r < 4; r++) col[r] = s[r*4+c];
               for (int r = 0; r < 4; r++) begin
                  s[r*4+c] = 8'h00;
                  for (int j = 0; j < 4; j++) s[r*4+c] ^= gf_mul(col[j], coef[(j - r + 4) % 4]);
               end
            end
         end
         if (act == ACT_ENCRYPT)
            for (int k = 0; k < 16; k++) s[k] ^= rk[i][k];
      end
      for (int k = 0; k < 16; k++) res[127 - 8*k -: 8] = s[k];
      return res;
   endfunction

   task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
      $display("mismatch %s: expected %h got %h", field, want, got);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // want holds {result_high, result_low}; tdata carries result_high in the low half
   always @(posedge clock) begin
      logic [127:0] want;
      if (reset) begin
         key_hi_q <= KEY_HIGH_RESET;
         key_lo_q <= KEY_LOW_RESET;
      end else begin
         if (req_tvalid && req_tready)
            cipher_out_q.push_back(aes_block({key_hi_q, key_lo_q},
                                             {req_tdata[63:0], req_tdata[127:64]}, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_out_q.size() == 0) begin
               $display("unexpected response %h", rsp_tdata);
               fail_count++;
            end else begin
               want = cipher_out_q.pop_front();
               if (rsp_tdata[63:0] !== want[127:64])
                  report("result_high", want[127:64], rsp_tdata[63:0]);
               if (rsp_tdata[127:64] !== want[63:0])
                  report("result_low", want[63:0], rsp_tdata[127:64]);
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_KEY_HIGH) key_hi_q <= csr_wdata;
            else if (csr_index == CSR_KEY_LOW) key_lo_q <= csr_wdata;
         end
      end
      pending <= cipher_out_q.size();
   end

endmodule

FILE: dv/aes128_block_cipher_tb.sv
// Testbench top for the AES-128 core: clock, reset, stimulus, watchdog and verdict.
module aes128_block_cipher_tb import aes_pkg::*;;

   localparam int STALL_LIMIT = 4000;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [127:0]         req_tdata;   // block_high, block_low
   logic                 req_tuser;   // action
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [127:0]         rsp_tdata;   // result_high, result_low
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [KEY_W-1:0]     csr_wdata;
   int                   fail_count;
   int                   pending;
   int                   send_idle_pct;
   int                   recv_stall_pct;
   int                   hold_cycles;
   int                   quiet_cycles;

   aes128_block_cipher dut (.*);

   aes128_block_cipher_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: random stalls, plus a long hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_block(input logic act, input logic [63:0] hi, input logic [63:0] lo);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {lo, hi};
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_key(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_blocks(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0)
            send_block(1'($urandom_range(1)), $urandom_range(1) ? '1 : '0, rand64());
         else
            send_block(1'($urandom_range(1)), rand64(), rand64());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_ENCRYPT;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_KEY_HIGH;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // built-in key: standard test blocks and field extremes, both directions
      send_block(ACT_ENCRYPT, 64'h328831e0435a3137, 64'hf6309807a88da234);
      send_block(ACT_DECRYPT, 64'h3902dc1925dc116a, 64'h8409850b1dfb9732);
      send_block(ACT_ENCRYPT, '0, '0);
      send_block(ACT_DECRYPT, '0, '0);
      send_block(ACT_ENCRYPT, '1, '1);
      send_block(ACT_DECRYPT, '1, '1);
      send_block(ACT_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
      send_block(ACT_DECRYPT, 64'h0000000000000001, 64'h8000000000000000);
      drain();
      // key change takes effect on the next block
      write_key(CSR_KEY_HIGH, '0);
      write_key(CSR_KEY_LOW, '0);
      send_block(ACT_ENCRYPT, '0, '0);
      send_block(ACT_DECRYPT, '1, '0);
      drain();
      write_key(CSR_KEY_HIGH, '1);
      write_key(CSR_KEY_LOW, '1);
      send_block(ACT_ENCRYPT, '1, '1);
      send_block(ACT_DECRYPT, '0, '1);
      drain();
      write_key(CSR_KEY_LOW, 64'h0123456789abcdef);
      send_block(ACT_ENCRYPT, 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
      send_block(ACT_DECRYPT, 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_key(CSR_KEY_HIGH, rand64());
         write_key(CSR_KEY_LOW, rand64());
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            default: begin send_idle_pct = $urandom_range(50); recv_stall_pct = $urandom_range(50); end
         endcase
         if (ph == 0) begin
            // long hold-off while requests keep coming, then wait for all results
            @(negedge clock);
            hold_cycles = 300;
            random_blocks(10);
            drain();
         end
         random_blocks(125);
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      @(negedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
